// ----- hw/rtl/sida_pkg.sv -----
// Package for the signed integer to decimal text converter.
// Holds the shared constants, state types and the converter hand-off struct.
// No dependencies.
package sida_pkg;

  // Default width of the input integer.
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Width of one character code on the output.
  localparam int unsigned CHAR_BITS = 6;

  // Width of one packed BCD digit.
  localparam int unsigned DIGIT_BITS = 4;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] DIGIT_ZERO = 6'd48;
  localparam logic [CHAR_BITS-1:0] DIGIT_NINE = 6'd57;
  localparam logic [CHAR_BITS-1:0] MINUS_SIGN = 6'd45;

  // Converter states.
  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_DONE
  } sida_conv_state_e;

  // Character emitter states.
  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_SIGN,
    E_EMIT
  } sida_emit_state_e;

  // Converter status handed to the emitter.
  typedef struct packed {
    logic done;
    logic neg;
  } sida_conv_t;

endpackage

// ----- hw/rtl/sida_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add three).
// Takes the magnitude of a signed word and shifts it in one bit per cycle.
// Depends on sida_pkg.
module sida_dabble import sida_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned NUM_DIGITS = (VALUE_BITS + 2) / 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [VALUE_BITS-1:0]            value_i,
  input  logic                             take_i,
  output logic                             busy_o,
  output sida_conv_t                       conv_o,
  output logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd_o
);

  localparam int unsigned BcdBits = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned CntBits = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  sida_conv_state_e      state_q, state_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [BcdBits-1:0]    bcd_adj;

  // Each digit of five or more gets three added before the shift, so that it
  // carries correctly into the next digit.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[VALUE_BITS-1];
          // The most negative value negates to the sign bit alone, which read
          // unsigned is exactly its magnitude.
          mag_d   = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
          bcd_d   = '0;
          cnt_d   = CntBits'(VALUE_BITS - 1);
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        bcd_d = {bcd_adj[BcdBits-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = C_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      C_DONE: begin
        if (take_i) begin
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o      = (state_q != C_IDLE);
  assign conv_o.done = (state_q == C_DONE);
  assign conv_o.neg  = neg_q;
  assign bcd_o       = bcd_q;

endmodule

// ----- hw/rtl/sida_emit.sv -----
// Character emitter: walks the BCD digits from the top, one per cycle while
// the output is not stalled. Drops leading zeros, puts out the minus sign
// and the digits as ASCII. Depends on sida_pkg.
module sida_emit import sida_pkg::*; #(
  parameter int unsigned NUM_DIGITS = (VALUE_BITS_DEF + 2) / 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sida_conv_t                       conv_i,
  input  logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd_i,
  output logic                             take_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [CHAR_BITS-1:0]             char_code_o,
  output logic                             last_char_o
);

  localparam int unsigned BcdBits = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned CntBits = $clog2(NUM_DIGITS + 1);

  sida_emit_state_e     state_q, state_d;
  logic [BcdBits-1:0]   dig_q, dig_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 oval_q, oval_d;
  logic [CHAR_BITS-1:0] char_q, char_d;
  logic                 last_q, last_d;
  logic [DIGIT_BITS-1:0] top_dig;
  logic                 can_push;

  assign top_dig  = dig_q[BcdBits-1 -: DIGIT_BITS];
  assign can_push = !oval_q || !out_stall_i;
  assign take_o   = conv_i.done && (state_q == E_IDLE);

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    oval_d  = oval_q && out_stall_i;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      E_IDLE: begin
        if (conv_i.done) begin
          dig_d   = bcd_i;
          neg_d   = conv_i.neg;
          cnt_d   = CntBits'(NUM_DIGITS);
          state_d = E_SKIP;
        end
      end
      E_SKIP: begin
        // The last digit is always kept, so that zero gives one '0'.
        if ((top_dig == '0) && (cnt_q > CntBits'(1))) begin
          dig_d = {dig_q[BcdBits-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end else if (neg_q) begin
          state_d = E_SIGN;
        end else begin
          state_d = E_EMIT;
        end
      end
      E_SIGN: begin
        if (can_push) begin
          oval_d  = 1'b1;
          char_d  = MINUS_SIGN;
          last_d  = 1'b0;
          state_d = E_EMIT;
        end
      end
      E_EMIT: begin
        if (can_push) begin
          oval_d = 1'b1;
          char_d = DIGIT_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_dig};
          last_d = (cnt_q == CntBits'(1));
          dig_d  = {dig_q[BcdBits-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
          cnt_d  = cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            state_d = E_IDLE;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = oval_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
// Top level of the signed integer to decimal ASCII text converter.
// Instantiates sida_dabble and sida_emit; depends on sida_pkg.
//
//   Channel  Direction  Handshake              Word
//   input    in         in_valid_i/in_stall_o   value_i
//   output   out        out_valid_o/out_stall_i char_code_o, last_char_o
//
// A word is taken when in_valid_i is high and in_stall_o is low. The converter
// then shifts the magnitude in one bit per cycle and stays busy until it has
// handed its digits to the emitter and returned to idle, so a new word is
// taken only after that hand-off. The emitter drops leading zeros at one digit
// a cycle and then gives one character a cycle while the output is not
// stalled; this overlaps the next conversion. Reset is asynchronous and
// active low and empties both stages. A stall on the output holds the
// character register and, behind it, the emitter and the converter; nothing
// is lost.
module signed_int_to_decimal_ascii_core import sida_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_BITS-1:0]  char_code_o,
  output logic                  last_char_o
);

  // Each decimal digit covers more than three bits, so this count always
  // holds the largest magnitude; surplus top digits are zero and get dropped.
  localparam int unsigned NumDigits = (VALUE_BITS + 2) / 3;

  sida_conv_t                      conv;
  logic [NumDigits*DIGIT_BITS-1:0] bcd;
  logic                            take;
  logic                            busy;
  logic                            accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy;

  // Converter: negates a negative word and runs the shift-and-add-three
  // conversion, holding the finished digits until the emitter takes them.
  sida_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NUM_DIGITS(NumDigits)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .value_i(value_i),
    .take_i (take),
    .busy_o (busy),
    .conv_o (conv),
    .bcd_o  (bcd)
  );

  // Emitter: turns the digits into characters behind an output register.
  sida_emit #(
    .NUM_DIGITS(NumDigits)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .conv_i     (conv),
    .bcd_i      (bcd),
    .take_o     (take),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

endmodule

// ----- hw/rtl/sida_port_checker.sv -----
// Checks on the ports of the decimal text converter, and its bind statement.
// Depends on sida_pkg and binds to signed_int_to_decimal_ascii_core.
module sida_port_checker import sida_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [CHAR_BITS-1:0]  char_code_o,
  input logic                  last_char_o
);

  // Only the minus sign and the ten digits are ever shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == MINUS_SIGN) ||
                    ((char_code_o >= DIGIT_ZERO) && (char_code_o <= DIGIT_NINE)))
    else $error("character outside the minus sign and the digits");

  // A minus sign is always followed by at least one digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (char_code_o == MINUS_SIGN)) |-> !last_char_o)
    else $error("minus sign marked as the last character");

  // A taken word keeps the converter busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // A stalled input word stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(value_i)))
    else $error("stalled input word changed or dropped");

  // A stalled character stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(char_code_o) && $stable(last_char_o)))
    else $error("stalled output word changed or dropped");

endmodule

bind signed_int_to_decimal_ascii_core sida_port_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_port_checker (.*);
